// File: hdl/tri_rast_pkg.sv
// ----------------------------------------------------------------------------
// tri_rast_pkg
// shared constants and types for the edge-function triangle raster scan
// ----------------------------------------------------------------------------
package tri_rast_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_A_X = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_A_Y = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_B_X = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_B_Y = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_C_X = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_C_Y = 3'd5;

  // stream widths
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_USER_BITS = 2;

  // per-position flags from the scan counter
  typedef struct packed {
    logic empty_row;
    logic row_end;
    logic frame_end;
    logic in_box;
  } scan_flags_t;

  // pipeline load strobes for an edge unit
  typedef struct packed {
    logic load_diff;
    logic load_prod;
  } edge_ctrl_t;

  // sign of one edge function
  typedef struct packed {
    logic ge0;
    logic le0;
  } edge_sign_t;

endpackage

// File: hdl/tri_rast_scan.sv
// ----------------------------------------------------------------------------
// tri_rast_scan
// scan position counter with bounding-box compare and row/frame marking
// ----------------------------------------------------------------------------
module tri_rast_scan #(
  parameter int COORD_BITS = tri_rast_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         restart,
  input  logic [COORD_BITS-1:0]        ax,
  input  logic [COORD_BITS-1:0]        ay,
  input  logic [COORD_BITS-1:0]        bx,
  input  logic [COORD_BITS-1:0]        by,
  input  logic [COORD_BITS-1:0]        cx,
  input  logic [COORD_BITS-1:0]        cy,
  output logic [COORD_BITS-1:0]        pos_x,
  output logic [COORD_BITS-1:0]        pos_y,
  output tri_rast_pkg::scan_flags_t    flags
);
  import tri_rast_pkg::*;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col, row;
  logic [COORD_BITS-1:0] min_ab_x, min_x, max_ab_x, max_x;
  logic [COORD_BITS-1:0] min_ab_y, min_y, max_ab_y, max_y;
  logic                  empty, col_last, row_last;

  // bounding box
  assign min_ab_x = (ax < bx) ? ax : bx;
  assign min_x    = (min_ab_x < cx) ? min_ab_x : cx;
  assign max_ab_x = (ax > bx) ? ax : bx;
  assign max_x    = (max_ab_x > cx) ? max_ab_x : cx;
  assign min_ab_y = (ay < by) ? ay : by;
  assign min_y    = (min_ab_y < cy) ? min_ab_y : cy;
  assign max_ab_y = (ay > by) ? ay : by;
  assign max_y    = (max_ab_y > cy) ? max_ab_y : cy;

  assign col = restart ? '0 : col_r;
  assign row = restart ? '0 : row_r;

  assign empty    = row < min_y;
  assign col_last = col >= max_x;
  assign row_last = row >= max_y;

  assign pos_x           = empty ? '0 : col;
  assign pos_y           = row;
  assign flags.empty_row = empty;
  assign flags.row_end   = empty | col_last;
  assign flags.frame_end = ~empty & col_last & row_last;
  assign flags.in_box    = ~empty & (col >= min_x);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (flags.row_end) begin
        col_nxt = '0;
        row_nxt = flags.frame_end ? '0 : row + COORD_BITS'(1);
      end else begin
        col_nxt = col + COORD_BITS'(1);
        row_nxt = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: hdl/tri_rast_edge.sv
// ----------------------------------------------------------------------------
// tri_rast_edge
// one edge function, differences then products, sign out of the last stage
// ----------------------------------------------------------------------------
module tri_rast_edge #(
  parameter int COORD_BITS = tri_rast_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  tri_rast_pkg::edge_ctrl_t   ctrl,
  input  logic [COORD_BITS-1:0]      ux,
  input  logic [COORD_BITS-1:0]      uy,
  input  logic [COORD_BITS-1:0]      vx,
  input  logic [COORD_BITS-1:0]      vy,
  input  logic [COORD_BITS-1:0]      px,
  input  logic [COORD_BITS-1:0]      py,
  output tri_rast_pkg::edge_sign_t   sign
);
  import tri_rast_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 1;

  logic signed [DW-1:0] dx, dy, qx, qy;
  logic signed [DW-1:0] dx_r, dy_r, qx_r, qy_r;
  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [EW-1:0] e;

  assign dx = $signed({1'b0, vx}) - $signed({1'b0, ux});
  assign dy = $signed({1'b0, vy}) - $signed({1'b0, uy});
  assign qx = $signed({1'b0, px}) - $signed({1'b0, ux});
  assign qy = $signed({1'b0, py}) - $signed({1'b0, uy});

  always_ff @(posedge clk) begin
    if (ctrl.load_diff) begin
      dx_r <= dx;
      dy_r <= dy;
      qx_r <= qx;
      qy_r <= qy;
    end
    if (ctrl.load_prod) begin
      p0_r <= PW'(dy_r) * PW'(qx_r);
      p1_r <= PW'(dx_r) * PW'(qy_r);
    end
  end

  // dy*qx - dx*qy, exact at one extra bit
  assign e = $signed({p0_r[PW-1], p0_r}) - $signed({p1_r[PW-1], p1_r});

  assign sign.ge0 = ~e[EW-1];
  assign sign.le0 = e[EW-1] | (e == '0);

endmodule

// File: hdl/triangle_edge_function_raster_scan.sv
// ----------------------------------------------------------------------------
// triangle_edge_function_raster_scan
// edge-function triangle rasterizer emitting one scan position per beat
// ----------------------------------------------------------------------------
// each input beat is registered in stage 1, stage 2, stage 3 and the output reg
// throughput: one beat per cycle without stalls, through the four-stage pipeline
//   (scan counter, edge differences, edge products, sign test / output reg)
// each stage holds its beat on a downstream stall and fills bubbles upstream
// reset: synchronous active-low rst_n clears scan position, vertices and all
//   pipeline valid bits; in_tready is high on the first cycle after reset
module triangle_edge_function_raster_scan #(
  parameter int COORD_BITS    = tri_rast_pkg::COORD_BITS_DEF,
  parameter int OUT_DATA_BITS = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration write port
  input  logic                                    cfg_wr_en,
  input  logic [tri_rast_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [COORD_BITS-1:0]                   cfg_wdata,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [tri_rast_pkg::IN_DATA_BITS-1:0]   in_tdata,   // restart
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [OUT_DATA_BITS-1:0]                out_tdata,  // pos_x, pos_y, covered
  output logic [tri_rast_pkg::OUT_USER_BITS-1:0]  out_tuser,  // empty_row, frame_end
  output logic                                    out_tlast   // row_end
);
  import tri_rast_pkg::*;

  localparam int PAD_BITS = OUT_DATA_BITS - 2 * COORD_BITS - 1;

  // vertex registers
  logic [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  // pipeline valid bits
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic s3_v_r, s3_v_nxt;
  logic out_v_r, out_v_nxt;

  // stage payloads
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r, s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  scan_flags_t           s1_f_r, s2_f_r, s3_f_r, out_f_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                  out_cov_r;

  // handshake / flow
  logic in_beat;
  logic out_free, s3_free, s2_free, s1_free;
  logic mv1, mv2, mv3;

  // scan counter outputs
  logic [COORD_BITS-1:0] scan_x, scan_y;
  scan_flags_t           scan_f;

  edge_ctrl_t edge_ctrl;
  edge_sign_t sign_ab, sign_bc, sign_ca;
  logic       covered;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_A_X: ax_r <= cfg_wdata;
        CFG_A_Y: ay_r <= cfg_wdata;
        CFG_B_X: bx_r <= cfg_wdata;
        CFG_B_Y: by_r <= cfg_wdata;
        CFG_C_X: cx_r <= cfg_wdata;
        CFG_C_Y: cy_r <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------- flow ctrl
  // each stage can take a beat when empty or when its own beat moves on
  assign out_free = ~out_v_r | out_tready;
  assign s3_free  = ~s3_v_r | out_free;
  assign s2_free  = ~s2_v_r | s3_free;
  assign s1_free  = ~s1_v_r | s2_free;

  assign mv3 = s3_v_r & out_free;
  assign mv2 = s2_v_r & s3_free;
  assign mv1 = s1_v_r & s2_free;

  assign in_tready = s1_free;
  assign in_beat   = in_tvalid & in_tready;

  always_comb begin
    s1_v_nxt  = in_beat | (s1_v_r & ~mv1);
    s2_v_nxt  = mv1 | (s2_v_r & ~mv2);
    s3_v_nxt  = mv2 | (s3_v_r & ~mv3);
    out_v_nxt = mv3 | (out_v_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // ------------------------------------------------------ stage 1: scan
  // position and box flags are settled at the input beat, the counter
  // steps on the same edge
  tri_rast_scan #(
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_beat),
    .restart (in_tdata[0]),
    .ax      (ax_r),
    .ay      (ay_r),
    .bx      (bx_r),
    .by      (by_r),
    .cx      (cx_r),
    .cy      (cy_r),
    .pos_x   (scan_x),
    .pos_y   (scan_y),
    .flags   (scan_f)
  );

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_x_r <= scan_x;
      s1_y_r <= scan_y;
      s1_f_r <= scan_f;
    end
    if (mv1) begin
      s2_x_r <= s1_x_r;
      s2_y_r <= s1_y_r;
      s2_f_r <= s1_f_r;
    end
    if (mv2) begin
      s3_x_r <= s2_x_r;
      s3_y_r <= s2_y_r;
      s3_f_r <= s2_f_r;
    end
  end

  // ------------------------------------------ stages 2-3: edge functions
  // differences load with the beat entering stage 2, products with stage 3
  assign edge_ctrl.load_diff = mv1;
  assign edge_ctrl.load_prod = mv2;

  tri_rast_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_ab (
    .clk  (clk),
    .ctrl (edge_ctrl),
    .ux   (ax_r),
    .uy   (ay_r),
    .vx   (bx_r),
    .vy   (by_r),
    .px   (s1_x_r),
    .py   (s1_y_r),
    .sign (sign_ab)
  );

  tri_rast_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_bc (
    .clk  (clk),
    .ctrl (edge_ctrl),
    .ux   (bx_r),
    .uy   (by_r),
    .vx   (cx_r),
    .vy   (cy_r),
    .px   (s1_x_r),
    .py   (s1_y_r),
    .sign (sign_bc)
  );

  tri_rast_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_ca (
    .clk  (clk),
    .ctrl (edge_ctrl),
    .ux   (cx_r),
    .uy   (cy_r),
    .vx   (ax_r),
    .vy   (ay_r),
    .px   (s1_x_r),
    .py   (s1_y_r),
    .sign (sign_ca)
  );

  // either winding counts; on-edge is inside; left of box and empty rows
  // are never covered
  assign covered = s3_f_r.in_box &
                   ((sign_ab.ge0 & sign_bc.ge0 & sign_ca.ge0) |
                    (sign_ab.le0 & sign_bc.le0 & sign_ca.le0));

  // -------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (mv3) begin
      out_x_r   <= s3_x_r;
      out_y_r   <= s3_y_r;
      out_f_r   <= s3_f_r;
      out_cov_r <= covered;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_BITS{1'b0}}, out_cov_r, out_y_r, out_x_r};
  assign out_tuser  = {out_f_r.frame_end, out_f_r.empty_row};
  assign out_tlast  = out_f_r.row_end;

endmodule

// File: hdl/tri_rast_chk.sv
// ----------------------------------------------------------------------------
// tri_rast_chk
// port-level checks on the raster scan result stream
// ----------------------------------------------------------------------------
module tri_rast_chk #(
  parameter int COORD_BITS    = tri_rast_pkg::COORD_BITS_DEF,
  parameter int OUT_DATA_BITS = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    out_tvalid,
  input logic                                    out_tready,
  input logic [OUT_DATA_BITS-1:0]                out_tdata,
  input logic [tri_rast_pkg::OUT_USER_BITS-1:0]  out_tuser,
  input logic                                    out_tlast
);
  import tri_rast_pkg::*;

  // output stream empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // empty row is a single uncovered beat at column zero that ends its row
  a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && !out_tuser[1] &&
    !out_tdata[2*COORD_BITS] && (out_tdata[COORD_BITS-1:0] == '0))
    else $error("malformed empty row beat");

  // frame end only on a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("frame end without row end");

endmodule

bind triangle_edge_function_raster_scan tri_rast_chk #(
  .COORD_BITS    (COORD_BITS),
  .OUT_DATA_BITS (OUT_DATA_BITS)
) u_tri_rast_chk (.*);
